@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, skipped while reset is asserted.
`define FJV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every rising edge, reset included.
`define FJV_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/fjv_pkg.sv @@
// ----------------------------------------------------------------------------
// fjv_pkg
// Widths, item and command types, and sequencer states for the Jacobian
// volume quadrature block.
// ----------------------------------------------------------------------------
package fjv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int WEIGHT_W  = 31;
    localparam int VOL_W     = 63;
    localparam int JAC_W     = 64;
    localparam int JAC_N     = 9;
    localparam int LIMB_W    = 32;
    localparam int OPA_W     = 192;
    localparam int ACC_W     = 224;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int NTERMS    = 6;
    localparam int PV_LSB    = 3 * FRAC_BITS;
    localparam int OVF_LSB   = PV_LSB + VOL_W;

    localparam logic [2:0] LIMBS_XY  = 3'd2;
    localparam logic [2:0] LIMBS_XYZ = 3'd4;
    localparam logic [2:0] LIMBS_W   = 3'd6;
    localparam logic [2:0] TERM_LAST = 3'(NTERMS - 1);

    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    typedef enum logic {
        KIND_NODE,
        KIND_POINT_END
    } item_kind_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t                pos_x;
        coord_t                pos_y;
        coord_t                pos_z;
        coord_t                grad_x;
        coord_t                grad_y;
        coord_t                grad_z;
        logic [WEIGHT_W-1:0]   weight;
        logic                  last_point;
        item_kind_t            kind;
    } item_t;

    typedef logic [JAC_N-1:0][JAC_W-1:0] jac_mat_t;

    typedef struct packed {
        logic                start;
        logic                last_point;
        logic [WEIGHT_W-1:0] weight;
        jac_mat_t            jac;
    } det_cmd_t;

    typedef enum logic [2:0] {
        DET_IDLE,
        DET_LOAD,
        DET_MUL_XY,
        DET_MUL_Z,
        DET_ACC,
        DET_DIFF,
        DET_MUL_W,
        DET_OUT
    } det_state_t;

endpackage

@@ rtl/core/fjv_front.sv @@
// ----------------------------------------------------------------------------
// fjv_front
// Input side: accepts node items, tags each as a plain node or as the end of
// a quadrature point, and buffers them in a short queue for the back end.
// ----------------------------------------------------------------------------
module fjv_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  fjv_pkg::coord_t               pos_x,
    input  fjv_pkg::coord_t               pos_y,
    input  fjv_pkg::coord_t               pos_z,
    input  fjv_pkg::coord_t               grad_x,
    input  fjv_pkg::coord_t               grad_y,
    input  fjv_pkg::coord_t               grad_z,
    input  logic [fjv_pkg::WEIGHT_W-1:0]  weight,
    input  logic                          last_node,
    input  logic                          last_point,
    output fjv_pkg::item_t                q_item,
    output logic                          q_vld,
    input  logic                          q_pop
);
    import fjv_pkg::*;

    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    cnt_reg;
    logic [QPTR_W:0]    cnt_next;
    item_t              in_item;
    logic               wr_en;
    logic               rd_en;

    always_comb
    begin
        in_item.pos_x      = pos_x;
        in_item.pos_y      = pos_y;
        in_item.pos_z      = pos_z;
        in_item.grad_x     = grad_x;
        in_item.grad_y     = grad_y;
        in_item.grad_z     = grad_z;
        in_item.weight     = weight;
        in_item.last_point = last_point;
        in_item.kind       = last_node ? KIND_POINT_END : KIND_NODE;
    end

    assign full   = (cnt_reg == (QPTR_W + 1)'(QDEPTH));
    assign q_vld  = (cnt_reg != '0);
    assign q_item = mem_reg[rd_ptr_reg];
    assign wr_en  = push && !full;
    assign rd_en  = q_pop && q_vld;

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/core/fjv_mac.sv @@
// ----------------------------------------------------------------------------
// fjv_mac
// Jacobian accumulator: nine multiply lanes form the outer product of
// position and gradient, then a saturating add folds it into the Jacobian.
// A point end hands the finished Jacobian to the determinant unit.
// ----------------------------------------------------------------------------
module fjv_mac (
    input  logic              clk,
    input  logic              rst_n,
    input  fjv_pkg::item_t    q_item,
    input  logic              q_vld,
    output logic              q_pop,
    input  logic              det_ready,
    output fjv_pkg::det_cmd_t det_cmd
);
    import fjv_pkg::*;

    logic signed [JAC_W-1:0] prod_reg  [JAC_N];
    logic signed [JAC_W-1:0] prod_next [JAC_N];
    logic                    s1_vld_reg;
    logic                    s1_vld_next;
    item_kind_t              s1_kind_reg;
    logic [WEIGHT_W-1:0]     s1_weight_reg;
    logic                    s1_lastp_reg;
    jac_mat_t                jac_reg;
    jac_mat_t                jac_next;
    jac_mat_t                jac_sum;
    coord_t                  pos  [3];
    coord_t                  grad [3];
    logic                    s1_adv;

    function automatic logic [JAC_W-1:0] sat_add(input logic [JAC_W-1:0] a,
                                                 input logic [JAC_W-1:0] b);
        logic [JAC_W-1:0] s;
        s = a + b;
        if ((a[JAC_W-1] == b[JAC_W-1]) && (s[JAC_W-1] != a[JAC_W-1]))
        begin
            sat_add = a[JAC_W-1] ? {1'b1, {(JAC_W-1){1'b0}}} : {1'b0, {(JAC_W-1){1'b1}}};
        end
        else
        begin
            sat_add = s;
        end
    endfunction

    always_comb
    begin
        pos[0]  = q_item.pos_x;
        pos[1]  = q_item.pos_y;
        pos[2]  = q_item.pos_z;
        grad[0] = q_item.grad_x;
        grad[1] = q_item.grad_y;
        grad[2] = q_item.grad_z;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r*3 + c] = pos[r] * grad[c];
            end
        end
    end

    assign s1_adv = s1_vld_reg && ((s1_kind_reg == KIND_NODE) || det_ready);
    assign q_pop  = q_vld && (!s1_vld_reg || s1_adv);

    always_comb
    begin
        for (int k = 0; k < JAC_N; k++)
        begin
            jac_sum[k] = sat_add(jac_reg[k], prod_reg[k] >>> FRAC_BITS);
        end

        jac_next = jac_reg;
        if (s1_adv)
        begin
            jac_next = (s1_kind_reg == KIND_POINT_END) ? '0 : jac_sum;
        end

        s1_vld_next = s1_vld_reg;
        if (q_pop)
        begin
            s1_vld_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_vld_next = 1'b0;
        end

        det_cmd.start      = s1_adv && (s1_kind_reg == KIND_POINT_END);
        det_cmd.last_point = s1_lastp_reg;
        det_cmd.weight     = s1_weight_reg;
        det_cmd.jac        = jac_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            jac_reg    <= '0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            jac_reg    <= jac_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int k = 0; k < JAC_N; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            s1_kind_reg   <= q_item.kind;
            s1_weight_reg <= q_item.weight;
            s1_lastp_reg  <= q_item.last_point;
        end
    end

endmodule

@@ rtl/core/fjv_det.sv @@
// ----------------------------------------------------------------------------
// fjv_det
// Determinant and volume sequencer: forms |det J| exactly, one 32-bit limb
// per cycle on two 32x32 multipliers, scales it by the weight, saturates,
// updates the running volume and holds the result for the consumer.
// ----------------------------------------------------------------------------
module fjv_det (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fjv_pkg::det_cmd_t          det_cmd,
    output logic                       det_ready,
    input  logic                       pop,
    output logic                       empty,
    output logic [fjv_pkg::VOL_W-1:0]  point_volume,
    output logic [fjv_pkg::VOL_W-1:0]  total_volume,
    output logic                       volume_done
);
    import fjv_pkg::*;

    det_state_t           state_reg;
    det_state_t           state_next;
    jac_mat_t             jac_reg;
    jac_mat_t             jac_next;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [WEIGHT_W-1:0]  weight_next;
    logic                 lastp_reg;
    logic                 lastp_next;
    logic [2:0]           term_reg;
    logic [2:0]           term_next;
    logic [OPA_W-1:0]     opa_reg;
    logic [OPA_W-1:0]     opa_next;
    logic [JAC_W-1:0]     opm_reg;
    logic [JAC_W-1:0]     opm_next;
    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [2:0]           limb_reg;
    logic [2:0]           limb_next;
    logic [2*LIMB_W-1:0]  pp_lo_reg;
    logic [2*LIMB_W-1:0]  pp_lo_next;
    logic [2*LIMB_W-1:0]  pp_hi_reg;
    logic [2*LIMB_W-1:0]  pp_hi_next;
    logic [2:0]           pp_idx_reg;
    logic [2:0]           pp_idx_next;
    logic                 pp_vld_reg;
    logic                 pp_vld_next;
    logic [OPA_W-1:0]     pos_reg;
    logic [OPA_W-1:0]     pos_next;
    logic [OPA_W-1:0]     neg_reg;
    logic [OPA_W-1:0]     neg_next;
    logic [VOL_W-1:0]     vsum_reg;
    logic [VOL_W-1:0]     vsum_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [VOL_W-1:0]     pvol_reg;
    logic [VOL_W-1:0]     pvol_next;
    logic [VOL_W-1:0]     tvol_reg;
    logic [VOL_W-1:0]     tvol_next;
    logic                 done_reg;
    logic                 done_next;

    logic [JAC_W-1:0]     tx;
    logic [JAC_W-1:0]     ty;
    logic [JAC_W-1:0]     tz;
    logic                 tneg;
    logic [LIMB_W-1:0]    a_limb;
    logic [2:0]           limb_cnt;
    logic                 engine_on;
    logic                 issue;
    logic                 engine_done;
    logic [ACC_W-1:0]     acc_add;
    logic [VOL_W-1:0]     pv_c;
    logic [VOL_W:0]       tsum_c;
    logic [VOL_W-1:0]     tvol_c;

    function automatic logic [JAC_W-1:0] mag(input logic [JAC_W-1:0] v);
        mag = v[JAC_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb
    begin
        case (term_reg)
            3'd0:
            begin
                tx = jac_reg[0]; ty = jac_reg[4]; tz = jac_reg[8]; tneg = 1'b0;
            end
            3'd1:
            begin
                tx = jac_reg[0]; ty = jac_reg[5]; tz = jac_reg[7]; tneg = 1'b1;
            end
            3'd2:
            begin
                tx = jac_reg[1]; ty = jac_reg[3]; tz = jac_reg[8]; tneg = 1'b1;
            end
            3'd3:
            begin
                tx = jac_reg[1]; ty = jac_reg[5]; tz = jac_reg[6]; tneg = 1'b0;
            end
            3'd4:
            begin
                tx = jac_reg[2]; ty = jac_reg[3]; tz = jac_reg[7]; tneg = 1'b0;
            end
            3'd5:
            begin
                tx = jac_reg[2]; ty = jac_reg[4]; tz = jac_reg[6]; tneg = 1'b1;
            end
            default:
            begin
                tx = '0; ty = '0; tz = '0; tneg = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (limb_reg)
            3'd0:    a_limb = opa_reg[0*LIMB_W +: LIMB_W];
            3'd1:    a_limb = opa_reg[1*LIMB_W +: LIMB_W];
            3'd2:    a_limb = opa_reg[2*LIMB_W +: LIMB_W];
            3'd3:    a_limb = opa_reg[3*LIMB_W +: LIMB_W];
            3'd4:    a_limb = opa_reg[4*LIMB_W +: LIMB_W];
            3'd5:    a_limb = opa_reg[5*LIMB_W +: LIMB_W];
            default: a_limb = '0;
        endcase

        case (state_reg)
            DET_MUL_XY: limb_cnt = LIMBS_XY;
            DET_MUL_Z:  limb_cnt = LIMBS_XYZ;
            DET_MUL_W:  limb_cnt = LIMBS_W;
            default:    limb_cnt = '0;
        endcase
    end

    assign engine_on   = (state_reg == DET_MUL_XY) || (state_reg == DET_MUL_Z)
                      || (state_reg == DET_MUL_W);
    assign issue       = engine_on && (limb_reg < limb_cnt);
    assign engine_done = (limb_reg == limb_cnt) && !pp_vld_reg;
    assign acc_add     = acc_reg
                       + (ACC_W'(pp_lo_reg) << {pp_idx_reg, 5'b0})
                       + (ACC_W'(pp_hi_reg) << {pp_idx_reg + 3'd1, 5'b0});

    assign pv_c   = (|acc_reg[ACC_W-1:OVF_LSB]) ? VOL_MAX : acc_reg[PV_LSB +: VOL_W];
    assign tsum_c = {1'b0, vsum_reg} + {1'b0, pv_c};
    assign tvol_c = tsum_c[VOL_W] ? VOL_MAX : tsum_c[VOL_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        jac_next     = jac_reg;
        weight_next  = weight_reg;
        lastp_next   = lastp_reg;
        term_next    = term_reg;
        opa_next     = opa_reg;
        opm_next     = opm_reg;
        acc_next     = acc_reg;
        limb_next    = limb_reg;
        pp_lo_next   = pp_lo_reg;
        pp_hi_next   = pp_hi_reg;
        pp_idx_next  = pp_idx_reg;
        pp_vld_next  = 1'b0;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        vsum_next    = vsum_reg;
        out_vld_next = out_vld_reg;
        pvol_next    = pvol_reg;
        tvol_next    = tvol_reg;
        done_next    = done_reg;

        if (pop && out_vld_reg)
        begin
            out_vld_next = 1'b0;
        end

        if (issue)
        begin
            pp_lo_next  = a_limb * opm_reg[LIMB_W-1:0];
            pp_hi_next  = a_limb * opm_reg[JAC_W-1:LIMB_W];
            pp_idx_next = limb_reg;
            pp_vld_next = 1'b1;
            limb_next   = limb_reg + 3'd1;
        end
        if (engine_on && pp_vld_reg)
        begin
            acc_next = acc_add;
        end

        case (state_reg)
            DET_IDLE:
            begin
                if (det_cmd.start)
                begin
                    jac_next    = det_cmd.jac;
                    weight_next = det_cmd.weight;
                    lastp_next  = det_cmd.last_point;
                    term_next   = '0;
                    pos_next    = '0;
                    neg_next    = '0;
                    state_next  = DET_LOAD;
                end
            end
            DET_LOAD:
            begin
                opa_next   = OPA_W'(mag(tx));
                opm_next   = mag(ty);
                acc_next   = '0;
                limb_next  = '0;
                state_next = DET_MUL_XY;
            end
            DET_MUL_XY:
            begin
                if (engine_done)
                begin
                    opa_next   = acc_reg[OPA_W-1:0];
                    opm_next   = mag(tz);
                    acc_next   = '0;
                    limb_next  = '0;
                    state_next = DET_MUL_Z;
                end
            end
            DET_MUL_Z:
            begin
                if (engine_done)
                begin
                    state_next = DET_ACC;
                end
            end
            DET_ACC:
            begin
                if (tx[JAC_W-1] ^ ty[JAC_W-1] ^ tz[JAC_W-1] ^ tneg)
                begin
                    neg_next = neg_reg + acc_reg[OPA_W-1:0];
                end
                else
                begin
                    pos_next = pos_reg + acc_reg[OPA_W-1:0];
                end
                if (term_reg == TERM_LAST)
                begin
                    state_next = DET_DIFF;
                end
                else
                begin
                    term_next  = term_reg + 3'd1;
                    state_next = DET_LOAD;
                end
            end
            DET_DIFF:
            begin
                opa_next   = (pos_reg >= neg_reg) ? (pos_reg - neg_reg) : (neg_reg - pos_reg);
                opm_next   = JAC_W'(weight_reg);
                acc_next   = '0;
                limb_next  = '0;
                state_next = DET_MUL_W;
            end
            DET_MUL_W:
            begin
                if (engine_done)
                begin
                    state_next = DET_OUT;
                end
            end
            DET_OUT:
            begin
                if (!out_vld_reg || pop)
                begin
                    pvol_next    = pv_c;
                    tvol_next    = tvol_c;
                    done_next    = lastp_reg;
                    out_vld_next = 1'b1;
                    vsum_next    = lastp_reg ? '0 : tvol_c;
                    state_next   = DET_IDLE;
                end
            end
            default:
            begin
                state_next = DET_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= DET_IDLE;
            limb_reg    <= '0;
            pp_vld_reg  <= 1'b0;
            vsum_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            limb_reg    <= limb_next;
            pp_vld_reg  <= pp_vld_next;
            vsum_reg    <= vsum_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        jac_reg    <= jac_next;
        weight_reg <= weight_next;
        lastp_reg  <= lastp_next;
        term_reg   <= term_next;
        opa_reg    <= opa_next;
        opm_reg    <= opm_next;
        acc_reg    <= acc_next;
        pp_lo_reg  <= pp_lo_next;
        pp_hi_reg  <= pp_hi_next;
        pp_idx_reg <= pp_idx_next;
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        pvol_reg   <= pvol_next;
        tvol_reg   <= tvol_next;
        done_reg   <= done_next;
    end

    assign det_ready    = (state_reg == DET_IDLE);
    assign empty        = !out_vld_reg;
    assign point_volume = pvol_reg;
    assign total_volume = tvol_reg;
    assign volume_done  = done_reg;

endmodule

@@ rtl/core/fem_jacobian_volume_quadrature.sv @@
// ----------------------------------------------------------------------------
// Element volume by quadrature: node items enter at one per cycle while the
// queue is not full. A point's result comes from the limb-serial determinant
// unit, which takes a new point only from idle, after the last result is held.
// Async reset clears the queue, Jacobian, running volume and result valid flag.
// ----------------------------------------------------------------------------
module fem_jacobian_volume_quadrature (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  fjv_pkg::coord_t               pos_x,
    input  fjv_pkg::coord_t               pos_y,
    input  fjv_pkg::coord_t               pos_z,
    input  fjv_pkg::coord_t               grad_x,
    input  fjv_pkg::coord_t               grad_y,
    input  fjv_pkg::coord_t               grad_z,
    input  logic [fjv_pkg::WEIGHT_W-1:0]  weight,
    input  logic                          last_node,
    input  logic                          last_point,
    input  logic                          pop,
    output logic                          empty,
    output logic [fjv_pkg::VOL_W-1:0]     point_volume,
    output logic [fjv_pkg::VOL_W-1:0]     total_volume,
    output logic                          volume_done
);
    import fjv_pkg::*;

    item_t     q_item;
    logic      q_vld;
    logic      q_pop;
    logic      det_ready;
    det_cmd_t  det_cmd;

    fjv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .grad_x     (grad_x),
        .grad_y     (grad_y),
        .grad_z     (grad_z),
        .weight     (weight),
        .last_node  (last_node),
        .last_point (last_point),
        .q_item     (q_item),
        .q_vld      (q_vld),
        .q_pop      (q_pop)
    );

    fjv_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_item    (q_item),
        .q_vld     (q_vld),
        .q_pop     (q_pop),
        .det_ready (det_ready),
        .det_cmd   (det_cmd)
    );

    fjv_det u_det (
        .clk          (clk),
        .rst_n        (rst_n),
        .det_cmd      (det_cmd),
        .det_ready    (det_ready),
        .pop          (pop),
        .empty        (empty),
        .point_volume (point_volume),
        .total_volume (total_volume),
        .volume_done  (volume_done)
    );

endmodule

@@ rtl/core/fjv_checker.sv @@
// ----------------------------------------------------------------------------
// fjv_checker
// Port-level checks on the volume quadrature block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fjv_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          full,
    input logic                          pop,
    input logic                          empty,
    input logic [fjv_pkg::VOL_W-1:0]     point_volume,
    input logic [fjv_pkg::VOL_W-1:0]     total_volume,
    input logic                          volume_done
);

    `FJV_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> empty && !full, "queues not empty in reset")

    `FJV_ASSERT(a_result_hold, clk, rst_n, !empty && !pop |=> !empty && $stable(point_volume) && $stable(total_volume) && $stable(volume_done), "waiting result changed")

    `FJV_ASSERT(a_total_covers_point, clk, rst_n, !empty |-> total_volume >= point_volume, "running volume below point volume")

endmodule

bind fem_jacobian_volume_quadrature fjv_checker u_fjv_checker (.*);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: element volume quadrature testbench
// Streams node items (position and shape gradient) into the block through its
// push/full queue and pops point results through empty/pop. A local predictor
// builds the Jacobian from the same items, forms |det J| times the weight,
// and keeps the running element volume, so that every popped transaction is
// checked field by field. Directed points cover rank-one and unit volumes,
// floor rounding, and volume saturation. Random elements follow under three
// idling mixes. A long point of extreme nodes then grows every Jacobian entry
// far past 32 bits.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fjv_pkg::*;

    localparam longint unsigned CYCLE_LIMIT    = 64'd2_000_000;
    localparam int unsigned     END_WAIT       = 200;
    localparam int unsigned     JAC_FILL_NODES = 48;
    localparam int unsigned     MAX_REPORTS    = 20;

    localparam coord_t C_MIN  = 32'sh8000_0000;
    localparam coord_t C_MAX  = 32'sh7FFF_FFFF;
    localparam coord_t C_ONE  = 32'sh0001_0000;
    localparam coord_t C_TWO  = 32'sh0002_0000;
    localparam coord_t C_MTWO = -32'sh0002_0000;

    localparam logic [WEIGHT_W-1:0] W_MAX  = '1;
    localparam logic [WEIGHT_W-1:0] W_ONE  = 31'h0001_0000;
    localparam logic [WEIGHT_W-1:0] W_HALF = 31'h0000_8000;

    localparam logic signed [JAC_W-1:0] JAC_HI = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [JAC_W-1:0] JAC_LO = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [VOL_W-1:0] point_volume;
        logic [VOL_W-1:0] total_volume;
        logic             done;
    } volume_result_t;

    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                push       = 1'b0;
    logic                pop        = 1'b0;
    coord_t              pos_x      = '0;
    coord_t              pos_y      = '0;
    coord_t              pos_z      = '0;
    coord_t              grad_x     = '0;
    coord_t              grad_y     = '0;
    coord_t              grad_z     = '0;
    logic [WEIGHT_W-1:0] weight     = '0;
    logic                last_node  = 1'b0;
    logic                last_point = 1'b0;
    logic                full;
    logic                empty;
    logic [VOL_W-1:0]    point_volume;
    logic [VOL_W-1:0]    total_volume;
    logic                volume_done;

    int unsigned     send_idle_pct    = 0;
    int unsigned     recv_idle_pct    = 0;
    int unsigned     error_count      = 0;
    int unsigned     nodes_sent       = 0;
    int unsigned     results_checked  = 0;
    int unsigned     elements_closed  = 0;
    int unsigned     saturated_points = 0;
    longint unsigned cycle_count      = 0;

    logic signed [JAC_W-1:0] jac_model [JAC_N];
    logic [VOL_W-1:0]        element_volume = '0;
    volume_result_t          pending_volumes [$];
    volume_result_t          head_volume;

    fem_jacobian_volume_quadrature dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .grad_x       (grad_x),
        .grad_y       (grad_y),
        .grad_z       (grad_z),
        .weight       (weight),
        .last_node    (last_node),
        .last_point   (last_point),
        .pop          (pop),
        .empty        (empty),
        .point_volume (point_volume),
        .total_volume (total_volume),
        .volume_done  (volume_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic signed [JAC_W-1:0] jac_sat_add(input logic signed [JAC_W-1:0] a,
                                                            input logic signed [JAC_W-1:0] b);
        logic signed [JAC_W:0] ea;
        logic signed [JAC_W:0] eb;
        logic signed [JAC_W:0] s;
        ea = a;
        eb = b;
        s  = ea + eb;
        if (s[JAC_W] != s[JAC_W-1])
        begin
            return s[JAC_W] ? JAC_LO : JAC_HI;
        end
        return s[JAC_W-1:0];
    endfunction

    function automatic logic signed [199:0] triple_product(input logic signed [JAC_W-1:0] a,
                                                           input logic signed [JAC_W-1:0] b,
                                                           input logic signed [JAC_W-1:0] c);
        logic signed [199:0] ea;
        logic signed [199:0] eb;
        logic signed [199:0] ec;
        ea = a;
        eb = b;
        ec = c;
        return ea * eb * ec;
    endfunction

    function automatic void predict_node(input coord_t px, input coord_t py, input coord_t pz,
                                         input coord_t gx, input coord_t gy, input coord_t gz,
                                         input logic [WEIGHT_W-1:0] w,
                                         input logic ln, input logic lp);
        coord_t                  p [3];
        coord_t                  g [3];
        logic signed [JAC_W-1:0] prod;
        logic signed [199:0]     det;
        logic [199:0]            det_mag;
        logic [255:0]            scaled;
        logic [VOL_W:0]          vol_sum;
        logic [VOL_W-1:0]        pv;
        volume_result_t          res;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        g[0] = gx;
        g[1] = gy;
        g[2] = gz;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod = p[r] * g[c];
                prod = prod >>> FRAC_BITS;
                jac_model[r*3+c] = jac_sat_add(jac_model[r*3+c], prod);
            end
        end
        if (!ln)
        begin
            return;
        end
        det = triple_product(jac_model[0], jac_model[4], jac_model[8])
            - triple_product(jac_model[0], jac_model[5], jac_model[7])
            - triple_product(jac_model[1], jac_model[3], jac_model[8])
            + triple_product(jac_model[1], jac_model[5], jac_model[6])
            + triple_product(jac_model[2], jac_model[3], jac_model[7])
            - triple_product(jac_model[2], jac_model[4], jac_model[6]);
        det_mag = det[199] ? -det : det;
        scaled  = {56'b0, det_mag} * {225'b0, w};
        scaled  = scaled >> (3 * FRAC_BITS);
        pv      = (|scaled[255:VOL_W]) ? VOL_MAX : scaled[VOL_W-1:0];
        vol_sum = {1'b0, element_volume} + {1'b0, pv};
        element_volume = vol_sum[VOL_W] ? VOL_MAX : vol_sum[VOL_W-1:0];
        res.point_volume = pv;
        res.total_volume = element_volume;
        res.done         = lp;
        pending_volumes.push_back(res);
        if (pv == VOL_MAX)
        begin
            saturated_points++;
        end
        if (lp)
        begin
            element_volume = '0;
            elements_closed++;
        end
        for (int i = 0; i < JAC_N; i++)
        begin
            jac_model[i] = '0;
        end
    endfunction

    function automatic coord_t pick_coord(input int unsigned mag_bits);
        logic [31:0] r;
        int unsigned style;
        style = $urandom_range(99);
        if (style < 70)
        begin
            r = $urandom & ((32'd1 << (mag_bits + 1)) - 32'd1);
            return coord_t'(r - (32'd1 << mag_bits));
        end
        if (style < 90)
        begin
            return coord_t'($urandom);
        end
        case ($urandom_range(4))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return '0;
            3:       return '1;
            default: return C_ONE;
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        int unsigned style;
        style = $urandom_range(99);
        if (style < 60)
        begin
            return WEIGHT_W'($urandom_range(0, 1 << 17));
        end
        if (style < 90)
        begin
            return WEIGHT_W'($urandom);
        end
        return ($urandom_range(1) == 1) ? W_MAX : '0;
    endfunction

    task automatic report_mismatch(input string what, input logic [VOL_W-1:0] want_v,
                                   input logic [VOL_W-1:0] got_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("tb_top: %s mismatch at cycle %0d, expected %0h, got %0h",
                     what, cycle_count, want_v, got_v);
        end
    endtask

    task automatic send_node(input coord_t px, input coord_t py, input coord_t pz,
                             input coord_t gx, input coord_t gy, input coord_t gz,
                             input logic [WEIGHT_W-1:0] w,
                             input logic ln, input logic lp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push       <= 1'b1;
        pos_x      <= px;
        pos_y      <= py;
        pos_z      <= pz;
        grad_x     <= gx;
        grad_y     <= gy;
        grad_z     <= gz;
        weight     <= w;
        last_node  <= ln;
        last_point <= lp;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
        predict_node(px, py, pz, gx, gy, gz, w, ln, lp);
        nodes_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_volumes.size() != 0);
    endtask

    task automatic test_rank_one_points();
        send_node(C_MAX, C_MIN, '0, C_MIN, C_MAX, '1, W_MAX, 1'b1, 1'b0);
        send_node(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, W_MAX, 1'b1, 1'b0);
        send_node('1, C_ONE, C_MAX, C_ONE, '1, '0, '0, 1'b1, 1'b1);
    endtask

    task automatic test_unit_volumes();
        // weight and last_point on inner nodes must be ignored
        send_node(C_ONE, '0, '0, C_ONE, '0, '0, W_MAX, 1'b0, 1'b1);
        send_node('0, C_ONE, '0, '0, C_ONE, '0, '0, 1'b0, 1'b1);
        send_node('0, '0, C_ONE, '0, '0, C_ONE, W_ONE, 1'b1, 1'b0);
        // mirrored cube: negative determinant
        send_node(C_MTWO, '0, '0, C_ONE, '0, '0, W_MAX, 1'b0, 1'b0);
        send_node('0, C_TWO, '0, '0, C_ONE, '0, '0, 1'b0, 1'b0);
        send_node('0, '0, C_TWO, '0, '0, C_ONE, W_HALF, 1'b1, 1'b1);
    endtask

    task automatic test_volume_saturation();
        send_node(C_MIN, '0, '0, C_MIN, '0, '0, '0, 1'b0, 1'b0);
        send_node('0, C_MIN, '0, '0, C_MIN, '0, '0, 1'b0, 1'b0);
        send_node('0, '0, C_MIN, '0, '0, C_MIN, W_MAX, 1'b1, 1'b1);
        // two points just below the cap: only the running volume saturates
        for (int k = 0; k < 2; k++)
        begin
            send_node(C_MIN, '0, '0, C_MIN, '0, '0, '0, 1'b0, 1'b0);
            send_node('0, C_MIN, '0, '0, C_ONE, '0, '0, 1'b0, 1'b0);
            send_node('0, '0, C_MIN, '0, '0, C_ONE, 31'd7, 1'b1, 1'(k));
        end
    endtask

    task automatic test_floor_rounding();
        send_node('1, 32'sd1, '1, 32'sd1, '1, 32'sd3, '0, 1'b0, 1'b0);
        send_node(32'sd3, '1, C_ONE, '1, 32'sd1, C_ONE, '0, 1'b0, 1'b0);
        send_node(C_ONE, '1, '0, '0, C_ONE, '1, W_MAX, 1'b1, 1'b1);
    endtask

    task automatic test_random_elements(input int unsigned n_items);
        int unsigned sent;
        int unsigned n_points;
        int unsigned n_nodes;
        logic        lp;
        sent = 0;
        while (sent < n_items)
        begin
            n_points = $urandom_range(1, 8);
            for (int unsigned pt = 0; pt < n_points; pt++)
            begin
                n_nodes = ($urandom_range(1) == 1) ? 8 : $urandom_range(1, 8);
                for (int unsigned nd = 0; nd < n_nodes; nd++)
                begin
                    if (nd == n_nodes - 1)
                    begin
                        // mostly close on the final point; sometimes early or never
                        lp = (pt == n_points - 1) ? ($urandom_range(9) != 0)
                                                  : ($urandom_range(19) == 0);
                        send_node(pick_coord(19), pick_coord(19), pick_coord(19),
                                  pick_coord(17), pick_coord(17), pick_coord(17),
                                  pick_weight(), 1'b1, lp);
                    end
                    else
                    begin
                        send_node(pick_coord(19), pick_coord(19), pick_coord(19),
                                  pick_coord(17), pick_coord(17), pick_coord(17),
                                  WEIGHT_W'($urandom), 1'b0, 1'($urandom));
                    end
                    sent++;
                end
            end
            if ($urandom_range(15) == 0)
            begin
                drain_results();
            end
        end
    endtask

    task automatic test_long_point();
        for (int unsigned k = 0; k < JAC_FILL_NODES; k++)
        begin
            send_node(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN,
                      WEIGHT_W'($urandom), 1'b0, 1'($urandom));
        end
        // close with mixed-sign extremes
        send_node(C_MAX, '0, '0, C_MIN, '0, '0, '0, 1'b0, 1'b0);
        send_node('0, C_MIN, '0, '0, '0, C_MAX, '0, 1'b0, 1'b0);
        send_node('0, '0, C_MAX, '0, C_MIN, '0, W_MAX, 1'b1, 1'b1);
    endtask

    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_volumes.size() == 0)
            begin
                report_mismatch("unexpected result", '0, point_volume);
            end
            else
            begin
                head_volume = pending_volumes.pop_front();
                if (point_volume !== head_volume.point_volume)
                begin
                    report_mismatch("point_volume", head_volume.point_volume, point_volume);
                end
                if (total_volume !== head_volume.total_volume)
                begin
                    report_mismatch("total_volume", head_volume.total_volume, total_volume);
                end
                if (volume_done !== head_volume.done)
                begin
                    report_mismatch("volume_done", VOL_W'(head_volume.done), VOL_W'(volume_done));
                end
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < JAC_N; i++)
        begin
            jac_model[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 71;
        test_rank_one_points();
        test_unit_volumes();
        test_volume_saturation();
        test_floor_rounding();
        test_random_elements(270);
        drain_results();

        send_idle_pct = 71;
        recv_idle_pct = 23;
        test_random_elements(270);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_elements(270);
        test_long_point();
        drain_results();

        repeat (END_WAIT) @(posedge clk);
        if (pending_volumes.size() != 0)
        begin
            report_mismatch("missing result", pending_volumes[0].point_volume, '0);
        end

        $display("tb_top: %0d node items, %0d point results checked, %0d elements closed",
                 nodes_sent, results_checked, elements_closed);
        $display("tb_top: %0d saturated point volumes, idling mixes 23/71, 71/23 and none",
                 saturated_points);
        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: %0d mismatches", error_count);
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/fjv_pkg.sv
rtl/core/fjv_front.sv
rtl/core/fjv_mac.sv
rtl/core/fjv_det.sv
rtl/core/fem_jacobian_volume_quadrature.sv
rtl/core/fjv_checker.sv
tb/tb_top.sv
